// ===== rtl/rhsq_pkg.sv =====
// Shared constants and codes for the rolling hash substring query core.
`default_nettype none
package rhsq_pkg;
    localparam int MAX_LEN = 4096;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN + 2);
    localparam int POS_W   = 13;
    localparam int VAL_W   = 31;
    localparam int LET_W   = 5;
    localparam int SYM_W   = 7;
    localparam int ACT_W   = 2;
    localparam int ENT_W   = LET_W + 2 * VAL_W;
    localparam int PROD_W  = 2 * VAL_W + 1;
    localparam int CNT_W   = $clog2(PROD_W + 1);

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FWD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_BWD  = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic REG_HASH_BASE = 1'b0;
    localparam logic REG_HASH_MOD  = 1'b1;

    localparam logic [VAL_W-1:0] BASE_RESET = 31'd31;
    localparam logic [VAL_W-1:0] MOD_RESET  = 31'd1000000007;
    localparam logic [VAL_W-1:0] MOD_MIN    = 31'd2;
endpackage
`default_nettype wire

// ===== rtl/rhsq_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module rhsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/rhsq_modmul.sv =====
// Multi-cycle (a*b + c) mod m unit: one multiply, then bit-serial remainder.
`default_nettype none
module rhsq_modmul
    import rhsq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [VAL_W-1:0] i_a,
    input  wire logic [VAL_W-1:0] i_b,
    input  wire logic [VAL_W-1:0] i_c,
    input  wire logic [VAL_W-1:0] i_m,
    output logic                  o_done,
    output logic      [VAL_W-1:0] o_result
);
    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [VAL_W-1:0]  r_m, n_m;
    logic              r_done, n_done;
    logic [VAL_W:0]    trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_prod = r_prod;
        n_rem  = r_rem;
        n_m    = r_m;
        n_done = 1'b0;
        trial  = {r_rem, r_prod[PROD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(PROD_W);
            n_prod = PROD_W'(i_a) * PROD_W'(i_b) + PROD_W'(i_c);
            n_rem  = '0;
            n_m    = i_m;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract the modulus when it fits
            if (trial >= {1'b0, r_m}) begin
                n_rem = VAL_W'(trial - {1'b0, r_m});
            end else begin
                n_rem = VAL_W'(trial);
            end
            n_prod = {r_prod[PROD_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_m    <= n_m;
    end

    assign o_done   = r_done;
    assign o_result = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without a running operation");
    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result < r_m)) else $error("remainder not reduced");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0)) else $error("counter running while idle");
endmodule
`default_nettype wire

// ===== rtl/rolling_hash_substring_query_core.sv =====
// Top level: control sequencer, configuration registers and hash memories.
//
// Usage: one command channel (start/busy) carries an action with its fields.
// A command is taken at a clock edge with start high and busy low.
// Load (action 0) stores one letter if the string is not full and extends the
// prefix hash and power of the base; it gives no result. A load marked is_last
// finishes the string and walks back over the stored letters to build suffix hashes.
// Forward (1) and backward (2) queries return one result: o_valid is high for
// exactly one cycle with o_hash_value and o_status; the receiver cannot stall.
// Action 3 is ignored.
// Loads and queries use the shared modular multiply unit: one multiply, then one
// remainder bit per cycle, for each modular operation. A load that stores a letter
// holds busy through two modular operations (prefix hash, power); is_last adds one
// per letter for the suffix walk. A valid query holds busy through three reads of the
// hash memories and two modular operations, and its result comes in the cycle after;
// a rejected query answers in the next cycle without raising busy.
// Reset clears the string (length zero, not finished) and sets the base to
// 31 and the modulus to 1000000007. The memories need no clearing pass.
// Configuration is an APB-style port: base at 0x0, modulus at 0x4.
`default_nettype none
module rolling_hash_substring_query_core
    import rhsq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic [SYM_W-1:0] i_symbol,
    input  wire logic             i_is_last,
    input  wire logic [POS_W-1:0] i_first_pos,
    input  wire logic [POS_W-1:0] i_last_pos,
    output logic                  o_valid,
    output logic      [VAL_W-1:0] o_hash_value,
    output logic                  o_status,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LD_CHK  = 4'd1;
    localparam logic [3:0] ST_LD_MUL1 = 4'd2;
    localparam logic [3:0] ST_LD_MUL2 = 4'd3;
    localparam logic [3:0] ST_SF_RD   = 4'd4;
    localparam logic [3:0] ST_SF_CAP  = 4'd5;
    localparam logic [3:0] ST_SF_MUL  = 4'd6;
    localparam logic [3:0] ST_Q_RD    = 4'd7;
    localparam logic [3:0] ST_Q_CAP   = 4'd8;
    localparam logic [3:0] ST_Q_MUL1  = 4'd9;
    localparam logic [3:0] ST_Q_MUL2  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [VAL_W-1:0] r_base, n_base, r_mod, n_mod, m_eff;
    logic [ACT_W-1:0] r_act, n_act;
    logic [LET_W-1:0] r_sym, n_sym;
    logic             r_last_flag, n_last_flag;
    logic [POS_W-1:0] r_first, n_first, r_lastp, n_lastp;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_complete, n_complete;
    logic [VAL_W-1:0] r_prefix_last, n_prefix_last, r_pow_last, n_pow_last;
    logic [VAL_W-1:0] r_new_pre, n_new_pre, r_s, n_s;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_step, n_step;
    logic [VAL_W-1:0] r_qa, n_qa, r_qb, n_qb;
    logic [VAL_W-1:0] r_op_a, n_op_a, r_op_b, n_op_b, r_op_c, n_op_c;
    logic             r_issued, n_issued;
    logic             r_out_valid, n_out_valid, r_out_status, n_out_status;
    logic [VAL_W-1:0] r_out_hash, n_out_hash;

    logic             mm_start, mm_done, in_mul, q_err, cfg_wr;
    logic [VAL_W-1:0] mm_res;
    logic [VAL_W:0]   sum;
    logic [POS_W-1:0] span;

    logic             a_we, b_we;
    logic [IDX_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [ENT_W-1:0] a_wdata, a_rdata;
    logic [VAL_W-1:0] b_wdata, b_rdata;
    logic [LET_W-1:0] a_letter;
    logic [VAL_W-1:0] a_prefix, a_pow;

    assign m_eff    = (r_mod < MOD_MIN) ? MOD_MIN : r_mod;
    assign busy     = (r_state != ST_IDLE);
    assign in_mul   = (r_state == ST_LD_MUL1) || (r_state == ST_LD_MUL2) ||
                      (r_state == ST_SF_MUL)  || (r_state == ST_Q_MUL1)  ||
                      (r_state == ST_Q_MUL2);
    assign mm_start = in_mul && !r_issued;
    assign span     = r_lastp - r_first + 1'b1;
    assign a_letter = a_rdata[ENT_W-1 -: LET_W];
    assign a_prefix = a_rdata[2*VAL_W-1:VAL_W];
    assign a_pow    = a_rdata[VAL_W-1:0];
    assign q_err    = !r_complete || (i_first_pos == '0) || (i_first_pos > i_last_pos) ||
                      (32'(i_last_pos) > 32'(r_len));
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_HASH_MOD) ? {1'b0, r_mod} : {1'b0, r_base};

    always_comb begin
        n_state = r_state;       n_base = r_base;        n_mod = r_mod;
        n_act = r_act;           n_sym = r_sym;          n_last_flag = r_last_flag;
        n_first = r_first;       n_lastp = r_lastp;      n_len = r_len;
        n_complete = r_complete; n_prefix_last = r_prefix_last;
        n_pow_last = r_pow_last; n_new_pre = r_new_pre;  n_s = r_s;
        n_idx = r_idx;           n_step = r_step;        n_qa = r_qa;
        n_qb = r_qb;             n_op_a = r_op_a;        n_op_b = r_op_b;
        n_op_c = r_op_c;         n_issued = r_issued;
        n_out_valid = 1'b0;      n_out_status = r_out_status;
        n_out_hash = r_out_hash;
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr = '0;
        b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
        sum = '0;

        if (cfg_wr) begin
            case (paddr[2])
                REG_HASH_BASE: n_base = pwdata[VAL_W-1:0];
                REG_HASH_MOD:  n_mod  = pwdata[VAL_W-1:0];
                default: ;
            endcase
        end

        if (mm_start) begin
            n_issued = 1'b1;
        end
        if (mm_done) begin
            n_issued = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_act       = i_action;
                    n_sym       = i_symbol[LET_W-1:0];
                    n_last_flag = i_is_last;
                    n_first     = i_first_pos;
                    n_lastp     = i_last_pos;
                    case (i_action)
                        ACT_LOAD: begin
                            // drop a finished string before the new letter
                            if (r_complete) begin
                                n_len         = '0;
                                n_complete    = 1'b0;
                                n_prefix_last = '0;
                                n_pow_last    = VAL_W'(1);
                            end
                            n_state = ST_LD_CHK;
                        end
                        ACT_FWD, ACT_BWD: begin
                            if (q_err) begin
                                n_out_valid  = 1'b1;
                                n_out_hash   = '0;
                                n_out_status = STATUS_ERR;
                            end else begin
                                n_step  = 2'd0;
                                n_state = ST_Q_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LD_CHK: begin
                if (32'(r_len) < MAX_LEN) begin
                    n_op_a  = r_prefix_last;
                    n_op_b  = r_base;
                    n_op_c  = VAL_W'(r_sym);
                    n_state = ST_LD_MUL1;
                end else if (r_last_flag) begin
                    n_complete = 1'b1;
                    n_idx      = IDX_W'(r_len);
                    n_s        = '0;
                    n_state    = ST_SF_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LD_MUL1: begin
                if (mm_done) begin
                    n_new_pre = mm_res;
                    n_op_a    = r_pow_last;
                    n_op_b    = r_base;
                    n_op_c    = '0;
                    n_state   = ST_LD_MUL2;
                end
            end
            ST_LD_MUL2: begin
                if (mm_done) begin
                    a_we          = 1'b1;
                    a_waddr       = IDX_W'(r_len + 1'b1);
                    a_wdata       = {r_sym, r_new_pre, mm_res};
                    n_prefix_last = r_new_pre;
                    n_pow_last    = mm_res;
                    n_len         = r_len + 1'b1;
                    if (r_last_flag) begin
                        n_complete = 1'b1;
                        n_idx      = IDX_W'(r_len + 1'b1);
                        n_s        = '0;
                        n_state    = ST_SF_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SF_RD: begin
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    a_raddr = r_idx;
                    n_state = ST_SF_CAP;
                end
            end
            ST_SF_CAP: begin
                n_op_a  = r_s;
                n_op_b  = r_base;
                n_op_c  = VAL_W'(a_letter);
                n_state = ST_SF_MUL;
            end
            ST_SF_MUL: begin
                if (mm_done) begin
                    b_we    = 1'b1;
                    b_waddr = r_idx;
                    b_wdata = mm_res;
                    n_s     = mm_res;
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_SF_RD;
                end
            end
            ST_Q_RD: begin
                case (r_step)
                    2'd0: begin
                        a_raddr = IDX_W'(r_lastp);
                        b_raddr = IDX_W'(r_first);
                    end
                    2'd1: begin
                        a_raddr = IDX_W'(r_first - 1'b1);
                        b_raddr = IDX_W'(r_lastp + 1'b1);
                    end
                    default: a_raddr = IDX_W'(span);
                endcase
                n_state = ST_Q_CAP;
            end
            ST_Q_CAP: begin
                case (r_step)
                    2'd0: begin
                        n_qa    = (r_act == ACT_FWD) ? a_prefix : b_rdata;
                        n_step  = 2'd1;
                        n_state = ST_Q_RD;
                    end
                    2'd1: begin
                        // prefix before position one and suffix past the end are zero
                        if (r_act == ACT_FWD) begin
                            n_qb = (r_first == POS_W'(1)) ? '0 : a_prefix;
                        end else begin
                            n_qb = (32'(r_lastp) == 32'(r_len)) ? '0 : b_rdata;
                        end
                        n_step  = 2'd2;
                        n_state = ST_Q_RD;
                    end
                    default: begin
                        n_op_a  = r_qb;
                        n_op_b  = a_pow;
                        n_op_c  = '0;
                        n_state = ST_Q_MUL1;
                    end
                endcase
            end
            ST_Q_MUL1: begin
                if (mm_done) begin
                    n_qb    = mm_res;
                    n_op_a  = r_qa;
                    n_op_b  = VAL_W'(1);
                    n_op_c  = '0;
                    n_state = ST_Q_MUL2;
                end
            end
            ST_Q_MUL2: begin
                if (mm_done) begin
                    sum = {1'b0, mm_res} + {1'b0, m_eff} - {1'b0, r_qb};
                    if (sum >= {1'b0, m_eff}) begin
                        sum = sum - {1'b0, m_eff};
                    end
                    n_out_valid  = 1'b1;
                    n_out_hash   = sum[VAL_W-1:0];
                    n_out_status = STATUS_OK;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_base        <= BASE_RESET;
            r_mod         <= MOD_RESET;
            r_len         <= '0;
            r_complete    <= 1'b0;
            r_prefix_last <= '0;
            r_pow_last    <= VAL_W'(1);
            r_issued      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_base        <= n_base;
            r_mod         <= n_mod;
            r_len         <= n_len;
            r_complete    <= n_complete;
            r_prefix_last <= n_prefix_last;
            r_pow_last    <= n_pow_last;
            r_issued      <= n_issued;
            r_out_valid   <= n_out_valid;
        end
        r_act        <= n_act;
        r_sym        <= n_sym;
        r_last_flag  <= n_last_flag;
        r_first      <= n_first;
        r_lastp      <= n_lastp;
        r_new_pre    <= n_new_pre;
        r_s          <= n_s;
        r_idx        <= n_idx;
        r_step       <= n_step;
        r_qa         <= n_qa;
        r_qb         <= n_qb;
        r_op_a       <= n_op_a;
        r_op_b       <= n_op_b;
        r_op_c       <= n_op_c;
        r_out_hash   <= n_out_hash;
        r_out_status <= n_out_status;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;
    assign o_status     = r_out_status;

    rhsq_modmul u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (r_op_a),
        .i_b      (r_op_b),
        .i_c      (r_op_c),
        .i_m      (m_eff),
        .o_done   (mm_done),
        .o_result (mm_res)
    );

    // entry n: letter n, prefix hash n, base power n
    rhsq_ram #(.WIDTH(ENT_W), .DEPTH(MAX_LEN + 1), .AW(IDX_W)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    rhsq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN + 1), .AW(IDX_W)) u_sfx_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while sequencer busy");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_ERR)) |-> (o_hash_value == '0))
        else $error("error result not zero");
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_OK)) |-> (o_hash_value < m_eff))
        else $error("hash not reduced");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_LEN) else $error("string length overflow");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the rolling hash substring query core: random and directed commands.
`timescale 1ns / 1ps
module testbench
    import rhsq_pkg::*;
();

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [VAL_W-1:0] hash_value;
        logic             status;
    } t_query_result;

    class t_hash_scoreboard;
        longint unsigned base_val;
        longint unsigned mod_val;
        logic [LET_W-1:0] letters [MAX_LEN];
        longint unsigned prefix [MAX_LEN + 1];
        longint unsigned suffix [MAX_LEN + 2];
        longint unsigned powers [MAX_LEN + 1];
        int unsigned length;
        bit complete;
        t_query_result pending_results [$];
        int errors;

        function new();
            base_val = 64'(BASE_RESET);
            mod_val = 64'(MOD_RESET);
            length = 0;
            complete = 0;
            errors = 0;
            prefix[0] = 0;
            powers[0] = 1;
        endfunction

        function void note_config(logic [2:0] addr, logic [31:0] value);
            if (addr[2] == REG_HASH_BASE) base_val = 64'(value[VAL_W-1:0]);
            else mod_val = 64'(value[VAL_W-1:0]);
        endfunction

        function void note_item(logic [ACT_W-1:0] action, logic [SYM_W-1:0] symbol,
                                logic is_last, logic [POS_W-1:0] first,
                                logic [POS_W-1:0] last);
            longint unsigned m;
            longint unsigned p;
            longint unsigned a;
            longint unsigned x;
            t_query_result res;
            m = (mod_val < 2) ? 2 : mod_val;
            if (action == ACT_LOAD) begin
                if (complete) begin
                    complete = 0;
                    length = 0;
                end
                if (length < MAX_LEN) begin
                    letters[length] = symbol[LET_W-1:0];
                    prefix[0] = 0;
                    powers[0] = 1 % m;
                    prefix[length + 1] = (prefix[length] * base_val + symbol[LET_W-1:0]) % m;
                    powers[length + 1] = (powers[length] * base_val) % m;
                    length++;
                end
                if (is_last) begin
                    complete = 1;
                    suffix[length + 1] = 0;
                    for (int i = length; i >= 1; i--)
                        suffix[i] = (suffix[i + 1] * base_val + letters[i - 1]) % m;
                end
            end else if (action == ACT_FWD || action == ACT_BWD) begin
                if (!complete || first == 0 || first > last || last > length) begin
                    res.hash_value = '0;
                    res.status = STATUS_ERR;
                end else begin
                    p = powers[last - first + 1] % m;
                    if (action == ACT_FWD) begin
                        a = prefix[last];
                        x = ((prefix[first - 1] % m) * p) % m;
                    end else begin
                        a = suffix[first];
                        x = ((suffix[last + 1] % m) * p) % m;
                    end
                    res.hash_value = VAL_W'(((a % m) + m - x) % m);
                    res.status = STATUS_OK;
                end
                pending_results.push_back(res);
            end
        endfunction

        function void check(logic [VAL_W-1:0] hash_value, logic status);
            t_query_result exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result hash %0d status %0d", $time, hash_value, status);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (hash_value !== exp_res.hash_value) begin
                $display("%0t: hash mismatch expected %0d actual %0d",
                         $time, exp_res.hash_value, hash_value);
                errors++;
            end
            if (status !== exp_res.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, exp_res.status, status);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [ACT_W-1:0] i_action;
    logic [SYM_W-1:0] i_symbol;
    logic             i_is_last;
    logic [POS_W-1:0] i_first_pos;
    logic [POS_W-1:0] i_last_pos;
    logic             o_valid;
    logic [VAL_W-1:0] o_hash_value;
    logic             o_status;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    t_hash_scoreboard hash_sb;
    bit idling_on;
    int idle_cycles = 0;
    int unsigned cur_len;
    bit cur_done;

    rolling_hash_substring_query_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_symbol(i_symbol), .i_is_last(i_is_last),
        .i_first_pos(i_first_pos), .i_last_pos(i_last_pos),
        .o_valid(o_valid), .o_hash_value(o_hash_value), .o_status(o_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) hash_sb.check(o_hash_value, o_status);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold start high until the transaction is taken; it may stay high for the next.
    task automatic send_item(logic [ACT_W-1:0] action, logic [SYM_W-1:0] symbol,
                             logic is_last, logic [POS_W-1:0] first,
                             logic [POS_W-1:0] last);
        start <= 1'b1;
        i_action <= action;
        i_symbol <= symbol;
        i_is_last <= is_last;
        i_first_pos <= first;
        i_last_pos <= last;
        do @(posedge i_clk); while (busy);
        hash_sb.note_item(action, symbol, is_last, first, last);
        if (action == ACT_LOAD) begin
            if (cur_done) begin
                cur_done = 0;
                cur_len = 0;
            end
            if (cur_len < MAX_LEN) cur_len++;
            if (is_last) cur_done = 1;
        end
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (hash_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        hash_sb.note_config(addr, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_query();
        logic [POS_W-1:0] f;
        logic [POS_W-1:0] l;
        logic [ACT_W-1:0] act;
        act = $urandom_range(0, 1) ? ACT_FWD : ACT_BWD;
        if (cur_len > 0 && $urandom_range(0, 7) != 0) begin
            f = POS_W'($urandom_range(1, cur_len));
            l = POS_W'($urandom_range(f, cur_len));
        end else begin
            f = POS_W'($urandom);
            l = POS_W'($urandom);
        end
        send_item(act, '0, 1'b0, f, l);
    endtask

    // Mostly whole strings followed by queries; some noise in between.
    task automatic random_phase(int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_item(ACT_NONE, SYM_W'($urandom), 1'($urandom),
                              POS_W'($urandom), POS_W'($urandom));
                end
                1: begin
                    send_item(ACT_LOAD, SYM_W'($urandom), 1'($urandom_range(0, 1)),
                              POS_W'($urandom), POS_W'($urandom));
                    n++;
                end
                2: begin
                    send_query();
                    n++;
                end
                default: begin
                    len = $urandom_range(1, 20);
                    for (int i = 0; i < len; i++)
                        send_item(ACT_LOAD, SYM_W'(($urandom_range(0, 15) == 0) ? $urandom
                                  : $urandom_range(65, 90)), i == len - 1,
                                  POS_W'($urandom), POS_W'($urandom));
                    n += len;
                    repeat ($urandom_range(2, 8)) begin
                        send_query();
                        n++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        hash_sb = new();
        idling_on = 1;
        cur_len = 0;
        cur_done = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = ACT_LOAD;
        i_symbol = '0;
        i_is_last = 1'b0;
        i_first_pos = '0;
        i_last_pos = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: query before finish, odd letter codes, range errors, ignored action.
        send_item(ACT_FWD, '0, 1'b0, 13'd1, 13'd1);
        send_item(ACT_LOAD, 7'd65, 1'b0, '0, '0);
        send_item(ACT_BWD, '0, 1'b0, 13'd1, 13'd1);
        send_item(ACT_LOAD, 7'd90, 1'b0, '0, '0);
        send_item(ACT_LOAD, 7'd0, 1'b0, '0, '0);
        send_item(ACT_LOAD, 7'd127, 1'b1, 13'h1fff, 13'h1fff);
        send_item(ACT_FWD, '0, 1'b0, 13'd1, 13'd4);
        send_item(ACT_BWD, '0, 1'b0, 13'd1, 13'd4);
        send_item(ACT_FWD, '0, 1'b0, 13'd2, 13'd3);
        send_item(ACT_BWD, '0, 1'b0, 13'd4, 13'd4);
        send_item(ACT_FWD, '0, 1'b0, 13'd0, 13'd2);
        send_item(ACT_BWD, '0, 1'b0, 13'd3, 13'd2);
        send_item(ACT_FWD, '0, 1'b0, 13'd1, 13'd5);
        send_item(ACT_BWD, '0, 1'b0, 13'h1fff, 13'h1fff);
        send_item(ACT_NONE, 7'd65, 1'b1, 13'd1, 13'd1);
        send_item(ACT_FWD, '0, 1'b0, 13'd1, 13'd1);
        send_item(ACT_LOAD, 7'd66, 1'b1, '0, '0);
        send_item(ACT_BWD, '0, 1'b0, 13'd1, 13'd1);
        send_item(ACT_FWD, '0, 1'b0, 13'd1, 13'd2);
        send_item(ACT_FWD, '0, 1'b0, 13'd4096, 13'd4096);
        send_item(ACT_BWD, '0, 1'b0, 13'd4095, 13'd4097);

        random_phase(60);
        wait_idle();
        write_reg({REG_HASH_BASE, 2'b00}, 32'd2);
        write_reg({REG_HASH_MOD, 2'b00}, 32'h7fffffff);
        random_phase(60);
        wait_idle();
        write_reg({REG_HASH_BASE, 2'b00}, 32'hfffffffe);
        random_phase(60);
        // Mid-string register change: start a string, then change the modulus.
        send_item(ACT_LOAD, 7'd70, 1'b0, '0, '0);
        send_item(ACT_LOAD, 7'd71, 1'b0, '0, '0);
        wait_idle();
        write_reg({REG_HASH_MOD, 2'b00}, 32'd1000003);
        send_item(ACT_LOAD, 7'd72, 1'b1, '0, '0);
        random_phase(60);
        wait_idle();
        write_reg({REG_HASH_MOD, 2'b00}, 32'd0);
        random_phase(40);
        wait_idle();
        write_reg({REG_HASH_MOD, 2'b00}, 32'd1);
        write_reg({REG_HASH_BASE, 2'b00}, 32'd0);
        random_phase(40);
        wait_idle();
        write_reg({REG_HASH_BASE, 2'b00}, $urandom);
        write_reg({REG_HASH_MOD, 2'b00}, $urandom_range(2, 32'h7fffffff));
        random_phase(60);
        wait_idle();
        write_reg({REG_HASH_BASE, 2'b00}, 32'd31);
        write_reg({REG_HASH_MOD, 2'b00}, 32'd1000000007);
        idling_on = 0;
        random_phase(60);

        wait_idle();
        if (hash_sb.errors == 0 && hash_sb.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/rhsq_pkg.sv
rtl/rhsq_ram.sv
rtl/rhsq_modmul.sv
rtl/rolling_hash_substring_query_core.sv
verif/testbench.sv
